>>> rtl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Types, codes and constants shared by the virtqueue request tracker modules.
// ----------------------------------------------------------------------------
package vrt_pkg;

  // Pool and ring geometry
  localparam int SLOT_COUNT  = 8;
  localparam int QUEUE_SIZE  = 32;
  localparam int SLOT_BYTES  = 19;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int QPOS_W      = $clog2(QUEUE_SIZE);

  // Slot area layout and descriptor constants
  localparam logic [31:0] STATUS_OFF    = 32'd16;
  localparam logic [31:0] STATUS_PRESET = 32'hff;
  localparam logic [9:0]  HDR_LEN       = 10'd16;
  localparam logic [9:0]  DATA_LEN      = 10'd512;
  localparam logic [9:0]  STATUS_LEN    = 10'd1;
  localparam logic [1:0]  F_NEXT        = 2'd1;
  localparam logic [1:0]  F_WRITE       = 2'd2;

  // Field widths
  localparam int IDX_W   = 5;
  localparam int CHK_W   = 3;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_READY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BASE    = 1'd1;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_USED   = 2'd1,
    OP_CHECK  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_HDR    = 3'd0,
    KIND_STATUS = 3'd1,
    KIND_DESC   = 3'd2,
    KIND_AVAIL  = 3'd3,
    KIND_NOTIFY = 3'd4,
    KIND_ANSWER = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CODE_OK        = 3'd0,
    CODE_NOT_READY = 3'd1,
    CODE_NULL_BUF  = 3'd2,
    CODE_NO_SLOT   = 3'd3,
    CODE_DEV_ERR   = 3'd4,
    CODE_NOT_DONE  = 3'd5,
    CODE_IGNORED   = 3'd6
  } code_e;

  // Result beats of a successful submit, in emission order
  typedef enum logic [2:0] {
    BEAT_HDR    = 3'd0,
    BEAT_STATUS = 3'd1,
    BEAT_DESC0  = 3'd2,
    BEAT_DESC1  = 3'd3,
    BEAT_DESC2  = 3'd4,
    BEAT_AVAIL  = 3'd5,
    BEAT_NOTIFY = 3'd6
  } beat_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [31:0]      sector;
    logic [31:0]      buffer_addr;
    logic [31:0]      used_id;
    logic [CHK_W-1:0] check_slot;
    logic [7:0]       status_byte;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] index;
    logic [31:0]      addr;
    logic [9:0]       length;
    logic [1:0]       desc_flags;
    logic [IDX_W-1:0] next_index;
    logic [31:0]      value;
    code_e            code;
    logic             last;
  } result_t;

  // Byte offset of a slot inside the slot area
  function automatic logic [31:0] slot_offset(input logic [SLOT_W-1:0] slot);
    logic [31:0] off;
    off = 32'(slot) * 32'(SLOT_BYTES);
    return off;
  endfunction

endpackage

>>> rtl/vrt_in_stage.sv
// ----------------------------------------------------------------------------
// vrt_in_stage
// Input register: holds one accepted word until the engine retires it.
// ----------------------------------------------------------------------------
module vrt_in_stage
  import vrt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  pop_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // Take a new word when empty or when the held one retires this cycle
  assign in_ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/vrt_out_stage.sv
// ----------------------------------------------------------------------------
// vrt_out_stage
// Output register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module vrt_out_stage
  import vrt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held word leaves this cycle
  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/vrt_engine.sv
// ----------------------------------------------------------------------------
// vrt_engine
// Slot pool state, config registers and per-beat result formation.
// ----------------------------------------------------------------------------
module vrt_engine
  import vrt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 item_valid_i,
  input  item_t                item_i,
  output logic                 pop_o,
  input  logic                 can_load_i,
  output logic                 load_o,
  output result_t              res_o
);

  logic                  device_ready_q;
  logic [31:0]           slot_base_q;
  logic [SLOT_COUNT-1:0] slot_busy_q, slot_busy_d;
  logic [SLOT_COUNT-1:0] slot_done_q, slot_done_d;
  logic [15:0]           avail_q, avail_d;
  beat_e                 beat_q, beat_d;

  logic              fire;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic              used_hit;
  logic [SLOT_W-1:0] used_slot;
  logic              used_ok;
  logic              chk_in_range;
  logic [SLOT_W-1:0] chk_slot;
  logic              chk_done;
  logic              submit_ok;
  logic [31:0]       hdr_addr;
  logic [31:0]       st_addr;
  logic [IDX_W-1:0]  head;
  logic [15:0]       avail_inc;
  result_t           res;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_ready_q <= 1'b0;
      slot_base_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEVICE_READY: device_ready_q <= cfg_data_i[0];
        CFG_SLOT_BASE:    slot_base_q    <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_busy_q[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  // Used id must equal 3*slot for some slot in the pool
  always_comb begin
    used_hit  = 1'b0;
    used_slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (item_i.used_id == 32'(3 * i)) begin
        used_hit  = 1'b1;
        used_slot = SLOT_W'(i);
      end
    end
  end

  assign used_ok      = used_hit && slot_busy_q[used_slot];
  assign chk_in_range = 32'(item_i.check_slot) < 32'(SLOT_COUNT);
  assign chk_slot     = SLOT_W'(item_i.check_slot);
  assign chk_done     = chk_in_range && slot_done_q[chk_slot];

  assign submit_ok = device_ready_q && (item_i.buffer_addr != '0) && free_found;

  // Addresses and ring values for the chosen slot
  assign hdr_addr  = slot_base_q + slot_offset(free_slot);
  assign st_addr   = slot_base_q + (slot_offset(free_slot) + STATUS_OFF);
  assign head      = IDX_W'(3 * int'(free_slot));
  assign avail_inc = avail_q + 16'd1;

  // Result word for the current beat
  always_comb begin
    res      = '0;
    res.kind = KIND_ANSWER;
    res.code = CODE_OK;
    res.last = 1'b1;
    case (item_i.opcode)
      OP_SUBMIT: begin
        if (!device_ready_q) begin
          res.code = CODE_NOT_READY;
        end else if (item_i.buffer_addr == '0) begin
          res.code = CODE_NULL_BUF;
        end else if (!free_found) begin
          res.code = CODE_NO_SLOT;
        end else begin
          res.last = 1'b0;
          case (beat_q)
            BEAT_HDR: begin
              res.kind  = KIND_HDR;
              res.index = IDX_W'(free_slot);
              res.addr  = hdr_addr;
              res.value = item_i.sector;
            end
            BEAT_STATUS: begin
              res.kind  = KIND_STATUS;
              res.index = IDX_W'(free_slot);
              res.addr  = st_addr;
              res.value = STATUS_PRESET;
            end
            BEAT_DESC0: begin
              res.kind       = KIND_DESC;
              res.index      = head;
              res.addr       = hdr_addr;
              res.length     = HDR_LEN;
              res.desc_flags = F_NEXT;
              res.next_index = head + IDX_W'(1);
            end
            BEAT_DESC1: begin
              res.kind       = KIND_DESC;
              res.index      = head + IDX_W'(1);
              res.addr       = item_i.buffer_addr;
              res.length     = DATA_LEN;
              res.desc_flags = F_NEXT | F_WRITE;
              res.next_index = head + IDX_W'(2);
            end
            BEAT_DESC2: begin
              res.kind       = KIND_DESC;
              res.index      = head + IDX_W'(2);
              res.addr       = st_addr;
              res.length     = STATUS_LEN;
              res.desc_flags = F_WRITE;
            end
            BEAT_AVAIL: begin
              res.kind  = KIND_AVAIL;
              res.index = IDX_W'(avail_q[QPOS_W-1:0]);
              res.value = 32'(head);
            end
            BEAT_NOTIFY: begin
              res.kind  = KIND_NOTIFY;
              res.value = 32'(avail_inc);
              res.last  = 1'b1;
            end
            default: begin
              res.last = 1'b1;
            end
          endcase
        end
      end
      OP_USED: begin
        if (used_ok) begin
          res.index = IDX_W'(used_slot);
        end else begin
          res.code = CODE_IGNORED;
        end
      end
      OP_CHECK: begin
        res.index = IDX_W'(item_i.check_slot);
        if (!chk_done) begin
          res.code = CODE_NOT_DONE;
        end else if (item_i.status_byte != '0) begin
          res.code = CODE_DEV_ERR;
        end
      end
      default: begin
        res.code = CODE_IGNORED;
      end
    endcase
  end

  assign fire   = item_valid_i && can_load_i;
  assign load_o = item_valid_i;
  assign pop_o  = fire && res.last;
  assign res_o  = res;

  // State commit on the final beat of an item, beat advance on the others
  always_comb begin
    slot_busy_d = slot_busy_q;
    slot_done_d = slot_done_q;
    avail_d     = avail_q;
    beat_d      = beat_q;
    if (fire) begin
      if (res.last) begin
        beat_d = BEAT_HDR;
        case (item_i.opcode)
          OP_SUBMIT: begin
            if (submit_ok) begin
              slot_busy_d[free_slot] = 1'b1;
              slot_done_d[free_slot] = 1'b0;
              avail_d                = avail_inc;
            end
          end
          OP_USED: begin
            if (used_ok) begin
              slot_done_d[used_slot] = 1'b1;
            end
          end
          OP_CHECK: begin
            if (chk_done) begin
              slot_done_d[chk_slot] = 1'b0;
              slot_busy_d[chk_slot] = 1'b0;
            end
          end
          default: ;
        endcase
      end else begin
        beat_d = beat_e'(beat_q + 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_busy_q <= '0;
      slot_done_q <= '0;
      avail_q     <= '0;
      beat_q      <= BEAT_HDR;
    end else begin
      slot_busy_q <= slot_busy_d;
      slot_done_q <= slot_done_d;
      avail_q     <= avail_d;
      beat_q      <= beat_d;
    end
  end

`ifndef SYNTHESIS
  // A done slot is always a busy slot
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_done_q & ~slot_busy_q) == '0)
    else $error("slot done without busy");

  // A beat past the first only exists while an item is held
  a_beat_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != BEAT_HDR) |-> item_valid_i)
    else $error("beat advanced without item");

  // Each notify advances the avail counter by one
  a_notify_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.kind == KIND_NOTIFY) |=> (avail_q == $past(avail_q) + 16'd1))
    else $error("avail count not advanced on notify");

  // A submit sequence always ends on the notify beat
  a_submit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.last && item_i.opcode == OP_SUBMIT && submit_ok)
      |-> (beat_q == BEAT_NOTIFY))
    else $error("submit retired early");
`endif

endmodule

>>> rtl/virtqueue_request_tracker_core.sv
// Path: an accepted word is held in the input register; the engine forms its results
// combinationally into the output register, which feeds the master side. Results pass
// one per cycle through the single output register while the sink accepts: one per beat
// for a good submit, one for each used entry, check or rejected submit.
// Reset: asynchronous, clears both registers' valid flags, slot flags, avail count,
// the submit beat counter and the configuration registers.
// ----------------------------------------------------------------------------
// virtqueue_request_tracker_core
// Driver side of a split virtqueue for block reads with a fixed slot pool.
// ----------------------------------------------------------------------------
module virtqueue_request_tracker_core
  import vrt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sector, buffer_addr, used_id, check_slot, status_byte, zero pad
  input  logic [111:0]         s_axis_tdata,
  // opcode
  input  logic [1:0]           s_axis_tuser,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // index, addr, length, desc_flags, next_index, value, code, zero pad
  output logic [95:0]          m_axis_tdata,
  // kind
  output logic [2:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    pop;
  logic    can_load;
  logic    load;
  result_t res_new;
  result_t res_out;

  // Unpack the input word
  always_comb begin
    in_item.opcode      = opcode_e'(s_axis_tuser);
    in_item.sector      = s_axis_tdata[31:0];
    in_item.buffer_addr = s_axis_tdata[63:32];
    in_item.used_id     = s_axis_tdata[95:64];
    in_item.check_slot  = s_axis_tdata[98:96];
    in_item.status_byte = s_axis_tdata[106:99];
  end

  vrt_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  vrt_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .can_load_i   (can_load),
    .load_o       (load),
    .res_o        (res_new)
  );

  vrt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res_new),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res_out)
  );

  // Pack the result word
  assign m_axis_tdata = {7'd0, res_out.code, res_out.value, res_out.next_index,
                         res_out.desc_flags, res_out.length, res_out.addr,
                         res_out.index};
  assign m_axis_tuser = res_out.kind;
  assign m_axis_tlast = res_out.last;

endmodule

>>> bench/vrt_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_result_checker
// Watches the configuration port and both streams of the request tracker,
// works out the result words each accepted input word must cause, and compares
// every result word leaving the block, field by field, in order.
// ----------------------------------------------------------------------------
module vrt_result_checker
  import vrt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // sector, buffer_addr, used_id, check_slot, status_byte, zero pad
  input  logic [111:0]         s_axis_tdata,
  // opcode
  input  logic [1:0]           s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // index, addr, length, desc_flags, next_index, value, code, zero pad
  input  logic [95:0]          m_axis_tdata,
  // kind
  input  logic [2:0]           m_axis_tuser,
  input  logic                 m_axis_tlast,
  output int                   mismatches_o,
  output int                   results_due_o,
  output int                   results_seen_o,
  output bit   [6:0]           codes_seen_o
);

  // Shadow copy of the tracker: registers, slot flags, ring counters
  logic                  ready_q   = 1'b0;
  logic [31:0]           base_q    = '0;
  logic [SLOT_COUNT-1:0] busy_q    = '0;
  logic [SLOT_COUNT-1:0] done_q    = '0;
  logic [15:0]           avail_cnt = '0;
  logic [15:0]           used_cnt  = '0;

  result_t results_due[$];
  int      mismatches   = 0;
  int      results_seen = 0;
  bit [6:0] codes_seen  = '0;

  function automatic result_t mk_result(input kind_e kind, input logic [4:0] index,
                                        input logic [31:0] addr, input logic [9:0] length,
                                        input logic [1:0] flags, input logic [4:0] next,
                                        input logic [31:0] value, input code_e code,
                                        input logic last);
    result_t r;
    r.kind       = kind;
    r.index      = index;
    r.addr       = addr;
    r.length     = length;
    r.desc_flags = flags;
    r.next_index = next;
    r.value      = value;
    r.code       = code;
    r.last       = last;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf({"kind=%0d index=%0d addr=%h length=%0d flags=%0d next=%0d ",
                      "value=%h code=%0d last=%0b"},
                     r.kind, r.index, r.addr, r.length, r.desc_flags, r.next_index,
                     r.value, r.code, r.last);
  endfunction

  task automatic queue_answer(input logic [4:0] index, input code_e code);
    results_due.push_back(mk_result(KIND_ANSWER, index, '0, '0, '0, '0, '0, code, 1'b1));
  endtask

  // Update the shadow state for one input word and queue what it causes
  task automatic track_request(input logic [1:0] op, input logic [111:0] d);
    logic [31:0]       sector, buf_addr, used_id, hdr, sts;
    logic [2:0]        cslot;
    logic [7:0]        status;
    logic [4:0]        head;
    logic [SLOT_W-1:0] sidx;
    int unsigned       id_slot;
    int                slot;
    sector   = d[31:0];
    buf_addr = d[63:32];
    used_id  = d[95:64];
    cslot    = d[98:96];
    status   = d[106:99];
    slot     = -1;
    case (op)
      OP_SUBMIT: begin
        if (!ready_q) queue_answer(5'd0, CODE_NOT_READY);
        else if (buf_addr == 32'd0) queue_answer(5'd0, CODE_NULL_BUF);
        else begin
          // lowest free slot wins
          for (int i = SLOT_COUNT - 1; i >= 0; i--) if (!busy_q[i]) slot = i;
          if (slot < 0) queue_answer(5'd0, CODE_NO_SLOT);
          else begin
            sidx = SLOT_W'(slot);
            busy_q[sidx] = 1'b1;
            done_q[sidx] = 1'b0;
            hdr  = base_q + 32'(slot) * 32'(SLOT_BYTES);
            sts  = hdr + STATUS_OFF;
            head = 5'(3 * slot);
            results_due.push_back(mk_result(KIND_HDR, 5'(slot), hdr, '0, '0, '0, sector,
                                            CODE_OK, 1'b0));
            results_due.push_back(mk_result(KIND_STATUS, 5'(slot), sts, '0, '0, '0,
                                            STATUS_PRESET, CODE_OK, 1'b0));
            results_due.push_back(mk_result(KIND_DESC, head, hdr, HDR_LEN, F_NEXT,
                                            head + 5'd1, '0, CODE_OK, 1'b0));
            results_due.push_back(mk_result(KIND_DESC, head + 5'd1, buf_addr, DATA_LEN,
                                            F_NEXT | F_WRITE, head + 5'd2, '0, CODE_OK, 1'b0));
            results_due.push_back(mk_result(KIND_DESC, head + 5'd2, sts, STATUS_LEN, F_WRITE,
                                            '0, '0, CODE_OK, 1'b0));
            results_due.push_back(mk_result(KIND_AVAIL, 5'(avail_cnt % QUEUE_SIZE), '0, '0,
                                            '0, '0, 32'(head), CODE_OK, 1'b0));
            avail_cnt = avail_cnt + 16'd1;
            results_due.push_back(mk_result(KIND_NOTIFY, '0, '0, '0, '0, '0,
                                            {16'd0, avail_cnt}, CODE_OK, 1'b1));
          end
        end
      end
      OP_USED: begin
        used_cnt = used_cnt + 16'd1;
        id_slot  = used_id / 3;
        sidx     = SLOT_W'(id_slot);
        if (used_id % 3 == 0 && id_slot < SLOT_COUNT && busy_q[sidx]) begin
          done_q[sidx] = 1'b1;
          queue_answer(5'(id_slot), CODE_OK);
        end else begin
          queue_answer(5'd0, CODE_IGNORED);
        end
      end
      OP_CHECK: begin
        if (cslot >= SLOT_COUNT || !done_q[cslot]) queue_answer(5'(cslot), CODE_NOT_DONE);
        else begin
          done_q[cslot] = 1'b0;
          busy_q[cslot] = 1'b0;
          queue_answer(5'(cslot), (status == 8'd0) ? CODE_OK : CODE_DEV_ERR);
        end
      end
      default: queue_answer(5'd0, CODE_IGNORED);
    endcase
  endtask

  // Compare one result word against the oldest one owed
  task automatic check_result();
    result_t    exp_r, act_r;
    logic [8:0] bad;
    act_r.kind       = kind_e'(m_axis_tuser);
    act_r.index      = m_axis_tdata[4:0];
    act_r.addr       = m_axis_tdata[36:5];
    act_r.length     = m_axis_tdata[46:37];
    act_r.desc_flags = m_axis_tdata[48:47];
    act_r.next_index = m_axis_tdata[53:49];
    act_r.value      = m_axis_tdata[85:54];
    act_r.code       = code_e'(m_axis_tdata[88:86]);
    act_r.last       = m_axis_tlast;
    results_seen++;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result word with nothing owed: %s", $time, show(act_r));
    end else begin
      exp_r = results_due.pop_front();
      if (exp_r.kind == KIND_ANSWER) codes_seen[exp_r.code] = 1'b1;
      bad = {exp_r.kind !== act_r.kind, exp_r.index !== act_r.index,
             exp_r.addr !== act_r.addr, exp_r.length !== act_r.length,
             exp_r.desc_flags !== act_r.desc_flags, exp_r.next_index !== act_r.next_index,
             exp_r.value !== act_r.value, exp_r.code !== act_r.code,
             exp_r.last !== act_r.last};
      if (|bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result word %0d wrong, fields kind..last = %b", $time,
                   results_seen, bad);
          $display("  expected %s", show(exp_r));
          $display("  actual   %s", show(act_r));
        end
      end
    end
  endtask

  // Results leave before new words are predicted: a word accepted now
  // cannot show on the master side at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q   = 1'b0;
      base_q    = '0;
      busy_q    = '0;
      done_q    = '0;
      avail_cnt = '0;
      used_cnt  = '0;
      results_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEVICE_READY: ready_q = cfg_data_i[0];
          CFG_SLOT_BASE:    base_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) track_request(s_axis_tuser, s_axis_tdata);
    end
    mismatches_o   <= mismatches;
    results_due_o  <= results_due.size();
    results_seen_o <= results_seen;
    codes_seen_o   <= codes_seen;
  end

endmodule

>>> bench/virtqueue_request_tracker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtqueue_request_tracker_core_test
// Drives submits, used ring entries and completion checks into the tracker
// under random stalls on both streams, across several register settings; a
// side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module virtqueue_request_tracker_core_test
  import vrt_pkg::*;
();

  localparam int         STALL_LIMIT = 2000;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [31:0]          cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [111:0]         s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [95:0]          m_axis_tdata;
  logic [2:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  int       mismatches;
  int       results_due;
  int       results_seen;
  bit [6:0] codes_seen;

  int idle_pct   = 20;
  int words_sent = 0;
  int op_count[4];
  int quiet_cycles;

  always #5 clk_i = ~clk_i;

  virtqueue_request_tracker_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  vrt_result_checker result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatches_o   (mismatches),
    .results_due_o  (results_due),
    .results_seen_o (results_seen),
    .codes_seen_o   (codes_seen)
  );

  // Receiver stalls at random
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);

  // Send one input word, with random gaps ahead of it
  task automatic send_word(input logic [1:0] op, input logic [31:0] sector,
                           input logic [31:0] buf_addr, input logic [31:0] used_id,
                           input logic [2:0] slot, input logic [7:0] status);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, status, slot, used_id, buf_addr, sector};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    op_count[op]++;
  endtask

  // Unused fields of each operation carry noise
  task automatic submit(input logic [31:0] sector, input logic [31:0] buf_addr);
    send_word(OP_SUBMIT, sector, buf_addr, $urandom(), 3'($urandom()), 8'($urandom()));
  endtask

  task automatic used(input logic [31:0] id);
    send_word(OP_USED, $urandom(), $urandom(), id, 3'($urandom()), 8'($urandom()));
  endtask

  task automatic check(input logic [2:0] slot, input logic [7:0] status);
    send_word(OP_CHECK, $urandom(), $urandom(), $urandom(), slot, status);
  endtask

  // Mix biased toward used ids and checks that hit live slots
  task automatic send_random_words(input int count);
    int          pick;
    logic [31:0] id;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        submit($urandom(), ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom());
      end else if (pick < 70) begin
        case ($urandom_range(0, 9))
          0: id = $urandom();
          1: id = 3 * $urandom_range(SLOT_COUNT, 12);
          2: id = 3 * $urandom_range(0, SLOT_COUNT - 1) + $urandom_range(1, 2);
          default: id = 3 * $urandom_range(0, SLOT_COUNT - 1);
        endcase
        used(id);
      end else if (pick < 99) begin
        check(3'($urandom_range(0, 7)),
              ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
      end else begin
        send_word(OP_UNUSED, $urandom(), $urandom(), $urandom(), 3'($urandom()),
                  8'($urandom()));
      end
    end
  endtask

  // Let every owed result drain before touching the registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Watchdog: ends the run when no word moves for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          cfg_we_i || !rst_ni)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("virtqueue_request_tracker_core_test failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Device not ready yet: submits rejected, other operations still answered
    submit(32'd1234, 32'h0000_1000);
    check(3'd0, 8'd0);
    used(32'd0);
    send_word(OP_UNUSED, '1, '1, '1, '1, '1);
    drain();

    // Slot area near the top of memory so addresses wrap
    write_reg(CFG_DEVICE_READY, 32'd1);
    write_reg(CFG_SLOT_BASE, 32'hFFFF_FFF0);
    submit(32'h0, 32'h0);
    submit(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    submit(32'h0, 32'h1);
    used(32'd0);
    used(32'd4);
    used(32'd27);
    used(32'hFFFF_FFFF);
    check(3'd1, 8'd0);
    check(3'd0, 8'hFF);
    used(32'd3);
    check(3'd1, 8'd0);
    // fill the pool, then one more finds no slot
    repeat (SLOT_COUNT + 1) submit($urandom(), $urandom() | 32'd1);
    used(32'd21);
    check(3'd7, 8'h80);
    check(3'd7, 8'd0);
    drain();

    write_reg(CFG_SLOT_BASE, 32'd0);
    send_random_words(100);
    drain();

    write_reg(CFG_SLOT_BASE, 32'hFFFF_FFFF);
    send_random_words(100);
    drain();

    write_reg(CFG_DEVICE_READY, 32'd0);
    write_reg(CFG_SLOT_BASE, $urandom());
    send_random_words(30);
    drain();

    // Back to back with no stalls, then stalls again
    write_reg(CFG_DEVICE_READY, 32'd1);
    write_reg(CFG_SLOT_BASE, $urandom());
    idle_pct = 0;
    send_random_words(80);
    idle_pct = 20;
    send_random_words(90);
    drain();
    repeat (10) @(posedge clk_i);

    $display("Summary: %0d words in (%0d submits, %0d used entries, %0d checks, %0d unused op)",
             words_sent, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("Summary: %0d result words checked, answer codes seen (6..0) %b, %0d mismatches",
             results_seen, codes_seen, mismatches);
    if (mismatches == 0 && results_due == 0)
      $display("virtqueue_request_tracker_core_test passed");
    else
      $display("virtqueue_request_tracker_core_test failed");
    $finish;
  end

endmodule

>>> files.f
rtl/vrt_pkg.sv
rtl/vrt_in_stage.sv
rtl/vrt_out_stage.sv
rtl/vrt_engine.sv
rtl/virtqueue_request_tracker_core.sv
bench/vrt_result_checker.sv
bench/virtqueue_request_tracker_core_test.sv
